@@ hw/rtl/wdps_pkg.sv @@
// Shared constants for the wall distance position snap block.
package wdps_pkg;

   // Result status codes, in order of precedence.
   localparam logic [2:0] STATUS_ACCEPTED   = 3'd0;
   localparam logic [2:0] STATUS_LOW_CONF   = 3'd1;
   localparam logic [2:0] STATUS_DISTANCE   = 3'd2;
   localparam logic [2:0] STATUS_MISALIGNED = 3'd3;
   localparam logic [2:0] STATUS_OUTSIDE    = 3'd4;

   // Configuration register indexes.
   localparam logic [2:0] CSR_MIN_CONFIDENCE  = 3'd0;
   localparam logic [2:0] CSR_MIN_DISTANCE    = 3'd1;
   localparam logic [2:0] CSR_MAX_DISTANCE    = 3'd2;
   localparam logic [2:0] CSR_ALIGN_TOLERANCE = 3'd3;
   localparam logic [2:0] CSR_WALL_FACE       = 3'd4;
   localparam logic [2:0] CSR_SANITY_MARGIN   = 3'd5;

   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 15;

   // Register values after reset.
   localparam logic [5:0]  RESET_MIN_CONFIDENCE  = 6'd30;
   localparam logic [14:0] RESET_MIN_DISTANCE    = 15'd200;
   localparam logic [14:0] RESET_MAX_DISTANCE    = 15'd3600;
   localparam logic [10:0] RESET_ALIGN_TOLERANCE = 11'd700;
   localparam logic [14:0] RESET_WALL_FACE       = 15'd7025;
   localparam logic [9:0]  RESET_SANITY_MARGIN   = 10'd300;

   // Millimetres to hundredths of an inch: (mm * 500 + 63) / 127.
   localparam logic [22:0] MM_SCALE      = 23'd500;
   localparam logic [22:0] MM_ROUND      = 23'd63;
   localparam logic [22:0] MM_DIVISOR    = 23'd127;
   localparam logic [23:0] RECIP_127     = 24'd8454660;   // floor(2^30 / 127)
   localparam int          RECIP_127_SHIFT = 30;

   // One turn and the bias that makes any heading sum positive.
   localparam logic [22:0] TURN          = 23'd36000;
   localparam logic [23:0] BEAM_BIAS     = 24'd2124000;   // 59 turns
   localparam logic [22:0] RECIP_TURN    = 23'd7635497;   // floor(2^38 / 36000)
   localparam int          RECIP_TURN_SHIFT = 38;

   // Quarter turns and the half-way points between cardinals.
   localparam logic [15:0] QUARTER_1 = 16'd9000;
   localparam logic [15:0] QUARTER_2 = 16'd18000;
   localparam logic [15:0] QUARTER_3 = 16'd27000;
   localparam logic [15:0] QUARTER_4 = 16'd36000;
   localparam logic [15:0] SNAP_1    = 16'd4500;
   localparam logic [15:0] SNAP_2    = 16'd13500;
   localparam logic [15:0] SNAP_3    = 16'd22500;
   localparam logic [15:0] SNAP_4    = 16'd31500;

   // Cosine as 1 - e^2/2 in Q1.16.
   localparam logic [22:0] COS_COEF  = 23'd4287109;
   localparam logic [47:0] COS_ROUND = 48'h0000_8000_0000;
   localparam logic [16:0] COS_ONE   = 17'd65536;
   localparam logic [34:0] PERP_ROUND = 35'd32768;

   localparam logic signed [17:0] POS_MAX = 18'sd32767;
   localparam logic signed [17:0] POS_MIN = -18'sd32768;

endpackage

@@ hw/rtl/wall_distance_position_snap.sv @@
// Wall distance position snap: an eight-stage pipeline from sensor beat to position beat.
//
//   channel   ports                      handshake
//   request   start, busy, req_*         beat taken when start is high and busy is low
//   response  rsp_valid, rsp_*           one-cycle strobe, the receiver cannot hold it off
//   config    csr_we, csr_index, csr_wdata   write when csr_we is high, no wait
//
// A request beat is taken in every cycle in which start is high; busy is never raised, as
// nothing downstream can push back. Each beat passes through the eight register stages
// of the pipeline to the response ports, and one beat leaves per cycle. Reset clears
// the valid bits of every stage and loads the configuration registers with their
// defaults; payload registers are not reset.
//
// Pipeline stages:
//   1  scale millimetres, bias heading plus mount angle, confidence check
//   2  reciprocal multiplies for the two constant divisions (by 127 and by one turn)
//   3  quotient correction: reading in hundredths of an inch, beam folded into one turn
//   4  distance window check, snap to a cardinal, absolute error and alignment check
//   5  square of the error, reading plus sensor offset
//   6  cosine in Q1.16
//   7  perpendicular distance
//   8  coordinate, field check, saturation and status
module wall_distance_position_snap
   import wdps_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic [5:0]                 req_confidence,
   input  logic [13:0]                req_distance_mm,
   input  logic signed [21:0]         req_heading,
   input  logic [15:0]                req_mount_angle,
   input  logic [10:0]                req_sensor_offset,
   output logic                       rsp_valid,
   output logic [2:0]                 rsp_status,
   output logic                       rsp_axis_is_x,
   output logic signed [15:0]         rsp_position,
   input  logic                       csr_we,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_wdata
);

   // ---------------------------------------------------------------------------------
   // Configuration registers. The user must let writes arrive only while no beat is
   // in flight, which the block does not enforce; every stage may read them directly.
   // ---------------------------------------------------------------------------------
   logic [5:0]  min_conf_ff;
   logic [14:0] min_dist_ff;
   logic [14:0] max_dist_ff;
   logic [10:0] align_tol_ff;
   logic [14:0] wall_face_ff;
   logic [9:0]  margin_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_conf_ff   <= RESET_MIN_CONFIDENCE;
         min_dist_ff   <= RESET_MIN_DISTANCE;
         max_dist_ff   <= RESET_MAX_DISTANCE;
         align_tol_ff  <= RESET_ALIGN_TOLERANCE;
         wall_face_ff  <= RESET_WALL_FACE;
         margin_ff     <= RESET_SANITY_MARGIN;
      end else if (csr_we) begin
         case (csr_index)
            CSR_MIN_CONFIDENCE:  min_conf_ff   <= csr_wdata[5:0];
            CSR_MIN_DISTANCE:    min_dist_ff   <= csr_wdata[14:0];
            CSR_MAX_DISTANCE:    max_dist_ff   <= csr_wdata[14:0];
            CSR_ALIGN_TOLERANCE: align_tol_ff  <= csr_wdata[10:0];
            CSR_WALL_FACE:       wall_face_ff  <= csr_wdata[14:0];
            CSR_SANITY_MARGIN:   margin_ff     <= csr_wdata[9:0];
            default: begin
               // Indexes beyond the register list are ignored.
            end
         endcase
      end
   end

   // The pipeline never stalls, so a beat is taken whenever start is high.
   assign busy = 1'b0;

   // ---------------------------------------------------------------------------------
   // Valid bits, one per stage.
   // ---------------------------------------------------------------------------------
   logic [7:0] valid_ff;
   logic [7:0] valid_in;

   assign valid_in = {valid_ff[6:0], start & ~busy};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // ---------------------------------------------------------------------------------
   // Stage 1. The rounded conversion (mm * 1000 + 127) / 254 is rewritten as
   // (mm * 500 + 63) / 127, which gives the same floor. The beam sum is biased by a
   // whole number of turns so that the fold below works on a positive value.
   // ---------------------------------------------------------------------------------
   logic        s1_low_conf_ff, s1_low_conf_in;
   logic [22:0] s1_m_ff, s1_m_in;
   logic [22:0] s1_spos_ff, s1_spos_in;
   logic [10:0] s1_offs_ff;
   logic signed [23:0] s1_sum;

   always_comb begin
      s1_low_conf_in = req_confidence < min_conf_ff;
      s1_m_in        = 23'(req_distance_mm) * MM_SCALE + MM_ROUND;
      s1_sum         = {{2{req_heading[21]}}, req_heading} + $signed({8'b0, req_mount_angle})
                       + $signed(BEAM_BIAS);
      s1_spos_in     = s1_sum[22:0];
   end

   always_ff @(posedge clock) begin
      s1_low_conf_ff <= s1_low_conf_in;
      s1_m_ff        <= s1_m_in;
      s1_spos_ff     <= s1_spos_in;
      s1_offs_ff     <= req_sensor_offset;
   end

   // ---------------------------------------------------------------------------------
   // Stage 2. Both constant divisions use a truncated reciprocal, so each quotient is
   // either exact or one short; stage 3 corrects it.
   // ---------------------------------------------------------------------------------
   logic        s2_low_conf_ff;
   logic [22:0] s2_m_ff;
   logic [22:0] s2_spos_ff;
   logic [10:0] s2_offs_ff;
   logic [15:0] s2_q0_ff, s2_q0_in;
   logic [6:0]  s2_q1_ff, s2_q1_in;
   logic [46:0] s2_dist_prod;
   logic [45:0] s2_turn_prod;

   always_comb begin
      s2_dist_prod = 47'(s1_m_ff) * 47'(RECIP_127);
      s2_turn_prod = 46'(s1_spos_ff) * 46'(RECIP_TURN);
      s2_q0_in     = s2_dist_prod[RECIP_127_SHIFT+15:RECIP_127_SHIFT];
      s2_q1_in     = s2_turn_prod[RECIP_TURN_SHIFT+6:RECIP_TURN_SHIFT];
   end

   always_ff @(posedge clock) begin
      s2_low_conf_ff <= s1_low_conf_ff;
      s2_m_ff        <= s1_m_ff;
      s2_spos_ff     <= s1_spos_ff;
      s2_offs_ff     <= s1_offs_ff;
      s2_q0_ff       <= s2_q0_in;
      s2_q1_ff       <= s2_q1_in;
   end

   // ---------------------------------------------------------------------------------
   // Stage 3. One compare and step per quotient gives the reading and the beam angle
   // in the range 0 to one turn.
   // ---------------------------------------------------------------------------------
   logic        s3_low_conf_ff;
   logic [10:0] s3_offs_ff;
   logic [15:0] s3_reading_ff, s3_reading_in;
   logic [15:0] s3_beam_ff, s3_beam_in;
   logic [22:0] s3_dist_rem;
   logic [22:0] s3_turn_rem;

   always_comb begin
      s3_dist_rem = s2_m_ff - 23'(s2_q0_ff) * MM_DIVISOR;
      s3_turn_rem = s2_spos_ff - 23'(s2_q1_ff) * TURN;
      s3_reading_in = (s3_dist_rem >= MM_DIVISOR) ? s2_q0_ff + 16'd1 : s2_q0_ff;
      s3_beam_in = (s3_turn_rem >= TURN) ? 16'(s3_turn_rem - TURN) : s3_turn_rem[15:0];
   end

   always_ff @(posedge clock) begin
      s3_low_conf_ff <= s2_low_conf_ff;
      s3_offs_ff     <= s2_offs_ff;
      s3_reading_ff  <= s3_reading_in;
      s3_beam_ff     <= s3_beam_in;
   end

   // ---------------------------------------------------------------------------------
   // Stage 4. The beam snaps to the nearest quarter turn; an angle exactly half-way
   // goes to the higher cardinal. A full turn counts as straight ahead again.
   // ---------------------------------------------------------------------------------
   logic        s4_low_conf_ff;
   logic        s4_dist_bad_ff, s4_dist_bad_in;
   logic        s4_misaligned_ff, s4_misaligned_in;
   logic [15:0] s4_reading_ff;
   logic [10:0] s4_offs_ff;
   logic [12:0] s4_aerr_ff, s4_aerr_in;
   logic [1:0]  s4_card_ff, s4_card_in;
   logic [15:0] s4_base;
   logic signed [16:0] s4_err;

   always_comb begin
      s4_dist_bad_in = (s3_reading_ff < {1'b0, min_dist_ff})
                       || (s3_reading_ff > {1'b0, max_dist_ff});
      if (s3_beam_ff >= SNAP_4) begin
         s4_base    = QUARTER_4;
         s4_card_in = 2'd0;
      end else if (s3_beam_ff >= SNAP_3) begin
         s4_base    = QUARTER_3;
         s4_card_in = 2'd3;
      end else if (s3_beam_ff >= SNAP_2) begin
         s4_base    = QUARTER_2;
         s4_card_in = 2'd2;
      end else if (s3_beam_ff >= SNAP_1) begin
         s4_base    = QUARTER_1;
         s4_card_in = 2'd1;
      end else begin
         s4_base    = '0;
         s4_card_in = 2'd0;
      end
      s4_err           = $signed({1'b0, s3_beam_ff}) - $signed({1'b0, s4_base});
      s4_aerr_in       = s4_err[16] ? 13'(-s4_err) : s4_err[12:0];
      s4_misaligned_in = s4_aerr_in > {2'b0, align_tol_ff};
   end

   always_ff @(posedge clock) begin
      s4_low_conf_ff   <= s3_low_conf_ff;
      s4_dist_bad_ff   <= s4_dist_bad_in;
      s4_misaligned_ff <= s4_misaligned_in;
      s4_reading_ff    <= s3_reading_ff;
      s4_offs_ff       <= s3_offs_ff;
      s4_aerr_ff       <= s4_aerr_in;
      s4_card_ff       <= s4_card_in;
   end

   // ---------------------------------------------------------------------------------
   // Stage 5. Square of the error and the length from the robot centre to the wall.
   // ---------------------------------------------------------------------------------
   logic [2:0]  s5_flags_ff;
   logic [1:0]  s5_card_ff;
   logic [24:0] s5_sq_ff, s5_sq_in;
   logic [16:0] s5_span_ff, s5_span_in;

   always_comb begin
      s5_sq_in   = 25'(26'(s4_aerr_ff) * 26'(s4_aerr_ff));
      s5_span_in = 17'(s4_reading_ff) + 17'(s4_offs_ff);
   end

   always_ff @(posedge clock) begin
      s5_flags_ff <= {s4_low_conf_ff, s4_dist_bad_ff, s4_misaligned_ff};
      s5_card_ff  <= s4_card_ff;
      s5_sq_ff    <= s5_sq_in;
      s5_span_ff  <= s5_span_in;
   end

   // ---------------------------------------------------------------------------------
   // Stage 6. Cosine of the error as one minus half its square in radians.
   // ---------------------------------------------------------------------------------
   logic [2:0]  s6_flags_ff;
   logic [1:0]  s6_card_ff;
   logic [16:0] s6_span_ff;
   logic [16:0] s6_cos_ff, s6_cos_in;
   logic [47:0] s6_cos_prod;

   always_comb begin
      s6_cos_prod = 48'(s5_sq_ff) * 48'(COS_COEF) + COS_ROUND;
      s6_cos_in   = COS_ONE - {1'b0, s6_cos_prod[47:32]};
   end

   always_ff @(posedge clock) begin
      s6_flags_ff <= s5_flags_ff;
      s6_card_ff  <= s5_card_ff;
      s6_span_ff  <= s5_span_ff;
      s6_cos_ff   <= s6_cos_in;
   end

   // ---------------------------------------------------------------------------------
   // Stage 7. Perpendicular distance; it never exceeds the span since the cosine is
   // at most one.
   // ---------------------------------------------------------------------------------
   logic [2:0]  s7_flags_ff;
   logic [1:0]  s7_card_ff;
   logic [16:0] s7_perp_ff, s7_perp_in;
   logic [34:0] s7_perp_prod;

   always_comb begin
      s7_perp_prod = 35'(s6_span_ff) * 35'(s6_cos_ff) + PERP_ROUND;
      s7_perp_in   = s7_perp_prod[32:16];
   end

   always_ff @(posedge clock) begin
      s7_flags_ff <= s6_flags_ff;
      s7_card_ff  <= s6_card_ff;
      s7_perp_ff  <= s7_perp_in;
   end

   // ---------------------------------------------------------------------------------
   // Stage 8. Coordinate on the facing axis. Walls at +Y and +X give wall_face minus
   // the distance, those at -Y and -X the distance minus wall_face. Any rejection
   // clears the axis flag and the position; checks keep their order of precedence.
   // ---------------------------------------------------------------------------------
   logic signed [17:0] s8_value;
   logic [17:0]        s8_mag;
   logic [16:0]        s8_limit;
   logic               s8_outside;
   logic signed [17:0] s8_sat;
   logic [2:0]         rsp_status_in;
   logic               rsp_axis_is_x_in;
   logic signed [15:0] rsp_position_in;
   logic [2:0]         rsp_status_ff;
   logic               rsp_axis_is_x_ff;
   logic signed [15:0] rsp_position_ff;

   always_comb begin
      if (s7_card_ff < 2'd2) begin
         s8_value = $signed({3'b0, wall_face_ff}) - $signed({1'b0, s7_perp_ff});
      end else begin
         s8_value = $signed({1'b0, s7_perp_ff}) - $signed({3'b0, wall_face_ff});
      end
      s8_mag     = s8_value[17] ? 18'(-s8_value) : 18'(s8_value);
      s8_limit   = 17'(wall_face_ff) + 17'(margin_ff);
      s8_outside = s8_mag > {1'b0, s8_limit};
      if (s8_value > POS_MAX) begin
         s8_sat = POS_MAX;
      end else if (s8_value < POS_MIN) begin
         s8_sat = POS_MIN;
      end else begin
         s8_sat = s8_value;
      end

      rsp_axis_is_x_in = 1'b0;
      rsp_position_in  = '0;
      if (s7_flags_ff[2]) begin
         rsp_status_in = STATUS_LOW_CONF;
      end else if (s7_flags_ff[1]) begin
         rsp_status_in = STATUS_DISTANCE;
      end else if (s7_flags_ff[0]) begin
         rsp_status_in = STATUS_MISALIGNED;
      end else if (s8_outside) begin
         rsp_status_in = STATUS_OUTSIDE;
      end else begin
         rsp_status_in    = STATUS_ACCEPTED;
         rsp_axis_is_x_in = s7_card_ff[0];
         rsp_position_in  = s8_sat[15:0];
      end
   end

   always_ff @(posedge clock) begin
      rsp_status_ff    <= rsp_status_in;
      rsp_axis_is_x_ff <= rsp_axis_is_x_in;
      rsp_position_ff  <= rsp_position_in;
   end

   assign rsp_valid     = valid_ff[7];
   assign rsp_status    = rsp_status_ff;
   assign rsp_axis_is_x = rsp_axis_is_x_ff;
   assign rsp_position  = rsp_position_ff;

endmodule

@@ dv/tb_top.sv @@
// Self-checking testbench for the wall distance position snap block.
module tb_top;
   import wdps_pkg::*;

   // Register indexes past the end of the register list: writes to them must be ignored.
   localparam logic [2:0] CSR_SPARE_LO = 3'd6;
   localparam logic [2:0] CSR_SPARE_HI = 3'd7;

   // Register values after reset, kept here so that a wrong default in the block shows up.
   localparam logic [5:0]  DEFAULT_MIN_CONFIDENCE  = 6'd30;
   localparam logic [14:0] DEFAULT_MIN_DISTANCE    = 15'd200;
   localparam logic [14:0] DEFAULT_MAX_DISTANCE    = 15'd3600;
   localparam logic [10:0] DEFAULT_ALIGN_TOLERANCE = 11'd700;
   localparam logic [14:0] DEFAULT_WALL_FACE       = 15'd7025;
   localparam logic [9:0]  DEFAULT_SANITY_MARGIN   = 10'd300;

   // Arithmetic constants of the snap calculation.
   localparam longint MM_NUMERATOR   = 1000;      // millimetres to hundredths of an inch
   localparam longint MM_DENOMINATOR = 254;
   localparam longint MM_HALF_STEP   = 127;
   localparam longint FULL_TURN      = 36000;     // hundredths of a degree
   localparam longint QUARTER_TURN   = 9000;
   localparam longint EIGHTH_TURN    = 4500;
   localparam longint COSINE_GAIN    = 4287109;   // (pi/18000)^2 / 2 in Q48
   localparam longint COSINE_ROUND   = 64'h8000_0000;
   localparam longint Q16_ONE        = 65536;
   localparam longint Q16_HALF       = 32768;
   localparam longint POSITION_TOP   = 32767;
   localparam longint POSITION_FLOOR = -32768;

   localparam int MAX_IDLE      = 17;    // longest gap drawn between two request beats
   localparam int SETTLE_CYCLES = 16;    // pipeline depth is eight, so this leaves room
   localparam int QUIET_LIMIT   = 2000;  // cycles without any beat before giving up

   typedef struct packed {
      logic [5:0]         confidence;
      logic [13:0]        distance_mm;
      logic signed [21:0] heading;
      logic [15:0]        mount_angle;
      logic [10:0]        sensor_offset;
   } reading_type;

   typedef struct packed {
      logic [2:0]         status;
      logic               axis_is_x;
      logic signed [15:0] position;
   } snap_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                start             = 1'b0;
   logic                busy;
   logic [5:0]          req_confidence    = '0;
   logic [13:0]         req_distance_mm   = '0;
   logic signed [21:0]  req_heading       = '0;
   logic [15:0]         req_mount_angle   = '0;
   logic [10:0]         req_sensor_offset = '0;
   logic                rsp_valid;
   logic [2:0]          rsp_status;
   logic                rsp_axis_is_x;
   logic signed [15:0]  rsp_position;
   logic                csr_we    = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [CSR_DATA_WIDTH-1:0]  csr_wdata = '0;

   // The testbench's own copy of the configuration registers.
   logic [5:0]  cfg_min_confidence  = DEFAULT_MIN_CONFIDENCE;
   logic [14:0] cfg_min_distance    = DEFAULT_MIN_DISTANCE;
   logic [14:0] cfg_max_distance    = DEFAULT_MAX_DISTANCE;
   logic [10:0] cfg_align_tolerance = DEFAULT_ALIGN_TOLERANCE;
   logic [14:0] cfg_wall_face       = DEFAULT_WALL_FACE;
   logic [9:0]  cfg_sanity_margin   = DEFAULT_SANITY_MARGIN;

   reading_type     reading_q[$];       // readings waiting to be sent
   snap_result_type snap_expect_q[$];   // predicted results, oldest first
   int           error_count = 0;
   int           idle_left   = 0;
   bit           idling_on   = 1'b1;

   wall_distance_position_snap dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_confidence    (req_confidence),
      .req_distance_mm   (req_distance_mm),
      .req_heading       (req_heading),
      .req_mount_angle   (req_mount_angle),
      .req_sensor_offset (req_sensor_offset),
      .rsp_valid         (rsp_valid),
      .rsp_status        (rsp_status),
      .rsp_axis_is_x     (rsp_axis_is_x),
      .rsp_position      (rsp_position),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Works out the result of one reading under the current register settings. The checks
   // run in order of precedence: confidence, distance window, alignment, then field bounds.
   // Any rejection leaves the axis flag and the position at zero.
   function automatic snap_result_type predict_snap(input reading_type r);
      snap_result_type res;
      longint hundredths, beam, quarter, err, abs_err, cos_q16, perp, coord, bound, mag;
      res.status    = STATUS_ACCEPTED;
      res.axis_is_x = 1'b0;
      res.position  = '0;
      if (longint'(r.confidence) < longint'(cfg_min_confidence)) begin
         res.status = STATUS_LOW_CONF;
         return res;
      end
      hundredths = (longint'(r.distance_mm) * MM_NUMERATOR + MM_HALF_STEP) / MM_DENOMINATOR;
      if (hundredths < longint'(cfg_min_distance) ||
          hundredths > longint'(cfg_max_distance)) begin
         res.status = STATUS_DISTANCE;
         return res;
      end
      // Fold the beam into one turn; the remainder truncates, so negative sums need a lift.
      beam = (longint'($signed(r.heading)) + longint'(r.mount_angle)) % FULL_TURN;
      if (beam < 0)
         beam += FULL_TURN;
      // Halfway beams round up to the next cardinal, which leaves the error at minus 4500.
      quarter = (beam + EIGHTH_TURN) / QUARTER_TURN;
      err     = beam - quarter * QUARTER_TURN;
      abs_err = (err < 0) ? -err : err;
      if (abs_err > longint'(cfg_align_tolerance)) begin
         res.status = STATUS_MISALIGNED;
         return res;
      end
      cos_q16 = Q16_ONE - ((abs_err * abs_err * COSINE_GAIN + COSINE_ROUND) >> 32);
      perp    = ((hundredths + longint'(r.sensor_offset)) * cos_q16 + Q16_HALF) >> 16;
      // Facing +Y or +X the wall lies ahead, facing -Y or -X it lies behind.
      if ((quarter & 3) < 2)
         coord = longint'(cfg_wall_face) - perp;
      else
         coord = perp - longint'(cfg_wall_face);
      bound = longint'(cfg_wall_face) + longint'(cfg_sanity_margin);
      mag   = (coord < 0) ? -coord : coord;
      if (mag > bound) begin
         res.status = STATUS_OUTSIDE;
         return res;
      end
      if (coord > POSITION_TOP)
         coord = POSITION_TOP;
      if (coord < POSITION_FLOOR)
         coord = POSITION_FLOOR;
      res.axis_is_x = quarter[0];
      res.position  = coord[15:0];
      return res;
   endfunction

   function automatic int draw_idle();
      return idling_on ? int'($urandom_range(MAX_IDLE)) : 0;
   endfunction

   // A reading built to get past every check most of the time: confidence at or above the
   // floor, a distance near or inside the window and a beam close to a cardinal, with a
   // heading that may be many turns either way.
   function automatic reading_type aligned_reading();
      reading_type r;
      int lo, hi, target, span, err, card, turns, mount, heading;
      lo = int'(cfg_min_distance);
      hi = int'(cfg_max_distance);
      if (lo > hi)
         hi = lo;
      case ($urandom_range(5))
         0:       target = lo;
         1:       target = hi;
         default: target = $urandom_range(hi, lo);
      endcase
      span = int'(cfg_align_tolerance) + 2;
      if (span > 4499)
         span = 4499;
      case ($urandom_range(7))
         0:       err = int'(cfg_align_tolerance);
         1:       err = -int'(cfg_align_tolerance);
         default: err = int'($urandom_range(2 * span)) - span;
      endcase
      mount   = ($urandom_range(7) == 0) ? $urandom_range(65535) : $urandom_range(35999);
      card    = $urandom_range(3);
      turns   = int'($urandom_range(112)) - 56;
      heading = turns * 36000 + card * 9000 + err - mount;
      r.confidence    = 6'($urandom_range(63, cfg_min_confidence));
      r.distance_mm   = 14'((target * 254 + 500) / 1000);
      r.heading       = 22'(heading);
      r.mount_angle   = 16'(mount);
      r.sensor_offset = 11'($urandom_range(2047));
      return r;
   endfunction

   function automatic reading_type noise_reading();
      reading_type r;
      r.confidence    = 6'($urandom);
      r.distance_mm   = 14'($urandom);
      r.heading       = 22'($urandom);
      r.mount_angle   = 16'($urandom);
      r.sensor_offset = 11'($urandom);
      return r;
   endfunction

   task automatic add_reading(input int conf, input int dmm, input int heading,
                              input int mount, input int offset);
      reading_type r;
      r.confidence    = 6'(conf);
      r.distance_mm   = 14'(dmm);
      r.heading       = 22'(heading);
      r.mount_angle   = 16'(mount);
      r.sensor_offset = 11'(offset);
      reading_q.push_back(r);
   endtask

   // Mostly well-formed readings with random content; the rest is raw noise that mostly
   // trips the early checks.
   task automatic queue_random(input int count, input bit with_idling);
      idling_on = with_idling;
      for (int n = 0; n < count; n++)
         reading_q.push_back(($urandom_range(9) < 7) ? aligned_reading() : noise_reading());
   endtask

   // Waits until every reading has been sent and every predicted result has come back,
   // then lets the pipeline settle before anything else happens.
   task automatic wait_drained();
      do
         @(negedge clock);
      while (reading_q.size() != 0 || start || snap_expect_q.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(input logic [2:0] index, input logic [14:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      case (index)
         CSR_MIN_CONFIDENCE:  cfg_min_confidence  = value[5:0];
         CSR_MIN_DISTANCE:    cfg_min_distance    = value[14:0];
         CSR_MAX_DISTANCE:    cfg_max_distance    = value[14:0];
         CSR_ALIGN_TOLERANCE: cfg_align_tolerance = value[10:0];
         CSR_WALL_FACE:       cfg_wall_face       = value[14:0];
         CSR_SANITY_MARGIN:   cfg_sanity_margin   = value[9:0];
         default: ;
      endcase
   endtask

   // Loads all six registers, then hits a spare index last so that any aliasing onto a
   // real register would corrupt the settings just written and show up in the results.
   task automatic configure(input int conf, input int min_dist, input int max_dist,
                            input int tolerance, input int half, input int margin);
      write_csr(CSR_MIN_CONFIDENCE, 15'(conf));
      write_csr(CSR_MIN_DISTANCE, 15'(min_dist));
      write_csr(CSR_MAX_DISTANCE, 15'(max_dist));
      write_csr(CSR_ALIGN_TOLERANCE, 15'(tolerance));
      write_csr(CSR_WALL_FACE, 15'(half));
      write_csr(CSR_SANITY_MARGIN, 15'(margin));
      write_csr($urandom_range(1) ? CSR_SPARE_HI : CSR_SPARE_LO, 15'($urandom));
      @(posedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   task automatic configure_in_range();
      int lo, hi, swap;
      lo = $urandom_range(20000);
      hi = $urandom_range(20000);
      if (lo > hi) begin
         swap = lo;
         lo   = hi;
         hi   = swap;
      end
      configure($urandom_range(63), lo, hi, $urandom_range(1500), $urandom_range(20000),
                $urandom_range(1000));
   endtask

   // Request side. A beat is taken at an edge where start is high and busy is low; that is
   // where the expected result is worked out, from the very values on the ports. After each
   // taken beat a fresh gap is drawn before the next reading goes out.
   always @(posedge clock) begin : driver
      reading_type seen;
      reading_type beat;
      bit       taken;
      taken = 1'b0;
      if (reset) begin
         start <= 1'b0;
         idle_left = 0;
      end else begin
         if (start && !busy) begin
            seen.confidence    = req_confidence;
            seen.distance_mm   = req_distance_mm;
            seen.heading       = req_heading;
            seen.mount_angle   = req_mount_angle;
            seen.sensor_offset = req_sensor_offset;
            snap_expect_q.push_back(predict_snap(seen));
            idle_left = draw_idle();
            taken = 1'b1;
         end
         // A beat that is still held off by busy simply stays on the ports.
         if (!start || taken) begin
            if (idle_left > 0) begin
               idle_left--;
               start <= 1'b0;
            end else if (reading_q.size() != 0) begin
               beat = reading_q.pop_front();
               req_confidence    <= beat.confidence;
               req_distance_mm   <= beat.distance_mm;
               req_heading       <= beat.heading;
               req_mount_angle   <= beat.mount_angle;
               req_sensor_offset <= beat.sensor_offset;
               start <= 1'b1;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // Response side. Every strobed beat is matched against the oldest prediction.
   always @(posedge clock) begin : monitor
      snap_result_type want;
      if (!reset && rsp_valid) begin
         if (snap_expect_q.size() == 0) begin
            $display("%0t: unexpected result beat, status %0d axis_is_x %0d position %0d",
                     $time, rsp_status, rsp_axis_is_x, rsp_position);
            error_count++;
         end else begin
            want = snap_expect_q.pop_front();
            if (rsp_status !== want.status) begin
               $display("%0t: status expected %0d, actual %0d", $time, want.status,
                        rsp_status);
               error_count++;
            end
            if (rsp_axis_is_x !== want.axis_is_x) begin
               $display("%0t: axis_is_x expected %0d, actual %0d", $time, want.axis_is_x,
                        rsp_axis_is_x);
               error_count++;
            end
            if (rsp_position !== want.position) begin
               $display("%0t: position expected %0d, actual %0d", $time, want.position,
                        rsp_position);
               error_count++;
            end
         end
      end
   end

   // Ends the run if neither side moves a beat for too long, which also catches a
   // result that never arrives.
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(negedge clock);
         if ((start && !busy) || rsp_valid)
            quiet = 0;
         else
            quiet++;
      end
      $display("FAILED: results differ");
      $finish;
   end

   initial begin : sequencer
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed readings under the default settings: confidence window 30..63, distance
      // window 200..3600, tolerance 700, wall face 7025, margin 300.
      idling_on = 1'b1;
      add_reading(0, 500, 0, 0, 0);                // confidence at zero
      add_reading(29, 500, 0, 0, 0);               // one below the confidence floor
      add_reading(30, 500, 0, 0, 0);               // at the floor, facing +Y
      add_reading(63, 0, 0, 0, 0);                 // zero distance
      add_reading(63, 16383, 0, 0, 2047);          // longest distance, largest offset
      add_reading(63, 50, 0, 0, 0);                // just below the distance window
      add_reading(63, 51, 0, 0, 0);                // just inside it
      add_reading(63, 914, 0, 0, 0);               // just inside the top of the window
      add_reading(63, 915, 0, 0, 0);               // just above it
      add_reading(45, 1000, 9000, 0, 2047);        // facing +X
      add_reading(45, 1000, 18000, 0, 2047);       // facing -Y
      add_reading(45, 1000, 27000, 0, 2047);       // facing -X
      add_reading(45, 1000, 4500, 0, 100);         // halfway beams snap upwards
      add_reading(45, 1000, 13500, 0, 100);
      add_reading(45, 1000, 0, 22500, 100);
      add_reading(45, 1000, 0, 31500, 100);
      add_reading(45, 800, 700, 0, 50);            // error right at the tolerance
      add_reading(45, 800, 701, 0, 50);            // one past it
      add_reading(45, 800, -700, 0, 50);           // negative error at the tolerance
      add_reading(45, 800, -701, 0, 50);
      add_reading(40, 1200, -2097152, 0, 300);     // most negative heading
      add_reading(40, 1200, 2097151, 35999, 300);  // most positive heading, mount just below a full turn
      add_reading(40, 1200, 0, 65535, 300);        // mount angle with every bit set
      add_reading(40, 1200, -1800000 + 9000, 0, 300);  // many turns below zero
      queue_random(100, 1'b1);
      wait_drained();

      // Every register at its lowest value: almost nothing gets through the field check.
      configure(0, 0, 0, 0, 0, 0);
      queue_random(40, 1'b1);
      wait_drained();

      // Wide-open window, largest field and margin, beats back to back.
      configure(0, 0, 32767, 2047, 32767, 1023);
      queue_random(100, 1'b0);
      wait_drained();

      // The top of each register's intended range.
      configure(63, 20000, 20000, 1500, 20000, 1000);
      queue_random(60, 1'b1);
      wait_drained();

      // Every register bit set.
      configure(63, 32767, 32767, 2047, 32767, 1023);
      queue_random(40, 1'b1);
      wait_drained();

      // A small field with a tight margin, so that many readings land outside it.
      configure(10, 100, 8000, 1500, 2000, 50);
      queue_random(100, 1'b1);
      wait_drained();

      // Random settings within the intended ranges, with and without gaps.
      for (int p = 0; p < 4; p++) begin
         configure_in_range();
         queue_random(90, p[0]);
         wait_drained();
      end

      // Random settings across the full register widths.
      configure($urandom_range(63), $urandom_range(32767), $urandom_range(32767),
                $urandom_range(2047), $urandom_range(32767), $urandom_range(1023));
      queue_random(60, 1'b1);
      wait_drained();

      if (error_count == 0 && snap_expect_q.size() == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule

@@ wall_distance_position_snap.f @@
hw/rtl/wdps_pkg.sv
hw/rtl/wall_distance_position_snap.sv
dv/tb_top.sv
